// File: design/trsa_pkg.sv
// ----------------------------------------------------------------------------
// trsa_pkg
// Shared constants, types and helpers of the toy RSA alphabet engine.
// ----------------------------------------------------------------------------
`default_nettype none

package trsa_pkg;

    localparam int ALPHABET_DEPTH = 64;
    localparam int MOD_WIDTH      = 31;
    localparam int ADDR_W         = $clog2(ALPHABET_DEPTH);
    localparam int CNT_W          = $clog2(ALPHABET_DEPTH + 1);
    localparam int LEN_W          = 7;
    localparam int CHAR_W         = 16;
    localparam int SLOT_W         = 6;
    localparam int CMD_W          = 2;
    localparam int STATUS_W       = 3;
    localparam int CFG_IDX_W      = 2;
    localparam int PROD_W         = MOD_WIDTH + ADDR_W;
    localparam int KEYK_W         = MOD_WIDTH + 6;
    localparam int DIV_W          = (PROD_W > KEYK_W) ? PROD_W : KEYK_W;
    localparam int DCNT_W         = $clog2(DIV_W + 1);
    localparam int IN_DATA_W      = 24;
    localparam int OUT_DATA_W     = 64;

    localparam logic [MOD_WIDTH-1:0] MODULUS_RST = MOD_WIDTH'(3233);
    localparam logic [MOD_WIDTH-1:0] TOTIENT_RST = MOD_WIDTH'(3120);
    localparam logic [MOD_WIDTH-1:0] MIN_TOTIENT = MOD_WIDTH'(3);

    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTIENT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPH_LEN = 2'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD    = 2'd0,
        CMD_DERIVE  = 2'd1,
        CMD_ENCRYPT = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_CIPHER  = 3'd0,
        ST_KEYS    = 3'd1,
        ST_NOT_FND = 3'd2,
        ST_NO_EXP  = 3'd3,
        ST_LOADED  = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIN,
        S_SRCH,
        S_SRCH_CHK,
        S_EXP,
        S_EXP_DIV,
        S_EXP_WAIT,
        S_GCD,
        S_GCD_WAIT,
        S_D_ADD,
        S_D_DIV,
        S_D_WAIT
    } t_state;

    typedef struct packed {
        logic                 start;
        logic [DIV_W-1:0]     dividend;
        logic [MOD_WIDTH-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_W-1:0]     quot;
        logic [MOD_WIDTH-1:0] rem;
    } t_div_rsp;

    function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= 16'h0041 && c <= 16'h005A) begin
            r = c + 16'h0020;
        end else if (c >= 16'h0400 && c <= 16'h040F) begin
            r = c + 16'h0050;
        end else if (c >= 16'h0410 && c <= 16'h042F) begin
            r = c + 16'h0020;
        end else if (c == 16'h04C0) begin
            r = 16'h04CF;
        end else if (c >= 16'h04C1 && c <= 16'h04CE) begin
            r = c[0] ? c + 16'h0001 : c;
        end else if ((c >= 16'h0460 && c <= 16'h0481) ||
                     (c >= 16'h048A && c <= 16'h04BF) ||
                     (c >= 16'h04D0 && c <= 16'h052F)) begin
            r = c[0] ? c : c + 16'h0001;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: design/trsa_ram.sv
// ----------------------------------------------------------------------------
// trsa_ram
// Alphabet store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module trsa_ram (
    input  wire logic                         i_clk,
    input  wire logic                         i_we,
    input  wire logic [trsa_pkg::ADDR_W-1:0]  i_waddr,
    input  wire logic [trsa_pkg::CHAR_W-1:0]  i_wdata,
    input  wire logic [trsa_pkg::ADDR_W-1:0]  i_raddr,
    output logic      [trsa_pkg::CHAR_W-1:0]  o_rdata
);

    logic [trsa_pkg::CHAR_W-1:0] r_mem [trsa_pkg::ALPHABET_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: design/trsa_div.sv
// ----------------------------------------------------------------------------
// trsa_div
// Restoring divider, one quotient bit per cycle; shared by gcd, key and cipher.
// ----------------------------------------------------------------------------
`default_nettype none

module trsa_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire trsa_pkg::t_div_req i_req,
    output trsa_pkg::t_div_rsp      o_rsp
);

    localparam int MW = trsa_pkg::MOD_WIDTH;
    localparam int DW = trsa_pkg::DIV_W;
    localparam int CW = trsa_pkg::DCNT_W;

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [MW-1:0] r_rem, n_rem;
    logic [DW-1:0] r_quo, n_quo;
    logic [MW-1:0] r_dvs, n_dvs;
    logic [MW:0]   shifted;

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_dvs   = r_dvs;
        shifted = {r_rem, r_quo[DW-1]};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(DW);
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_dvs  = i_req.divisor;
        end else if (r_busy) begin
            if (shifted >= {1'b0, r_dvs}) begin
                n_rem = MW'(shifted - {1'b0, r_dvs});
                n_quo = {r_quo[DW-2:0], 1'b1};
            end else begin
                n_rem = shifted[MW-1:0];
                n_quo = {r_quo[DW-2:0], 1'b0};
            end
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

`default_nettype wire

// File: design/textbook_rsa_alphabet_encrypt_core.sv
// ----------------------------------------------------------------------------
// textbook_rsa_alphabet_encrypt_core
// Toy RSA engine: alphabet load, key derivation and character encryption.
// ----------------------------------------------------------------------------
// One item is taken at a time; ready is high only while idle, and a finished
// result waits in the output register while the next item is accepted. All
// long work runs through one divider, which yields 37 quotient bits per
// operation. Key derivation runs Euclid remainders over every trial exponent,
// then one division per trial multiple of the totient. An encryption scans
// the alphabet memory entry by entry through its registered read, and then
// does one multiply-mod per unit of the public exponent. The alphabet memory
// is not cleared after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module textbook_rsa_alphabet_encrypt_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // config port
    input  wire logic                                i_cfg_we,
    input  wire logic [trsa_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [trsa_pkg::MOD_WIDTH-1:0]      i_cfg_data,
    // input items
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [trsa_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // slot, character
    input  wire logic [trsa_pkg::CMD_W-1:0]          s_axis_tuser,  // cmd
    // result items
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic      [trsa_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // value, private_exp
    output logic      [trsa_pkg::STATUS_W-1:0]       m_axis_tuser   // status
);

    localparam int MW = trsa_pkg::MOD_WIDTH;
    localparam int AW = trsa_pkg::ADDR_W;
    localparam int NW = trsa_pkg::CNT_W;
    localparam int HW = trsa_pkg::CHAR_W;
    localparam int PW = trsa_pkg::PROD_W;
    localparam int DW = trsa_pkg::DIV_W;

    trsa_pkg::t_state r_state, n_state;

    logic [MW-1:0]                r_mod, r_tot;
    logic [trsa_pkg::LEN_W-1:0]   r_alen;

    logic [HW-1:0]  r_key, n_key;
    logic [NW-1:0]  r_len, n_len;
    logic [NW-1:0]  r_j, n_j;
    logic [AW-1:0]  r_pos, n_pos;
    logic [MW-1:0]  r_e, n_e;
    logic [MW-1:0]  r_a, n_a;
    logic [MW-1:0]  r_b, n_b;
    logic [DW-1:0]  r_k, n_k;
    logic [MW-1:0]  r_jd, n_jd;
    logic [MW-1:0]  r_c, n_c;
    logic [MW-1:0]  r_h, n_h;
    logic [PW-1:0]  r_prod, n_prod;
    logic [MW-1:0]  r_pub, n_pub;

    logic [trsa_pkg::STATUS_W-1:0] r_res_st, n_res_st;
    logic [MW-1:0]                 r_res_val, n_res_val;
    logic [MW-1:0]                 r_res_prv, n_res_prv;

    logic                          r_out_valid, n_out_valid;
    logic [trsa_pkg::STATUS_W-1:0] r_out_st, n_out_st;
    logic [MW-1:0]                 r_out_val, n_out_val;
    logic [MW-1:0]                 r_out_prv, n_out_prv;

    logic                    accept;
    logic [trsa_pkg::SLOT_W-1:0] in_slot;
    logic [HW-1:0]           in_char;
    logic                    ram_we;
    logic [AW-1:0]           ram_raddr;
    logic [HW-1:0]           ram_rdata;
    trsa_pkg::t_div_req      div_req;
    trsa_pkg::t_div_rsp      div_rsp;

    assign in_slot = s_axis_tdata[trsa_pkg::SLOT_W-1:0];
    assign in_char = s_axis_tdata[trsa_pkg::SLOT_W +: HW];
    assign accept  = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == trsa_pkg::S_IDLE);
    assign ram_we  = accept && (trsa_pkg::t_cmd'(s_axis_tuser) == trsa_pkg::CMD_LOAD) &&
                     (32'(in_slot) < 32'(trsa_pkg::ALPHABET_DEPTH));
    assign ram_raddr = r_j[AW-1:0];

    trsa_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(in_slot)),
        .i_wdata (in_char),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    trsa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod  <= trsa_pkg::MODULUS_RST;
            r_tot  <= trsa_pkg::TOTIENT_RST;
            r_alen <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                trsa_pkg::CFG_MODULUS:  r_mod  <= i_cfg_data;
                trsa_pkg::CFG_TOTIENT:  r_tot  <= i_cfg_data;
                trsa_pkg::CFG_ALPH_LEN: r_alen <= i_cfg_data[trsa_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state   = r_state;
        n_key     = r_key;
        n_len     = r_len;
        n_j       = r_j;
        n_pos     = r_pos;
        n_e       = r_e;
        n_a       = r_a;
        n_b       = r_b;
        n_k       = r_k;
        n_jd      = r_jd;
        n_c       = r_c;
        n_h       = r_h;
        n_prod    = r_prod;
        n_pub     = r_pub;
        n_res_st  = r_res_st;
        n_res_val = r_res_val;
        n_res_prv = r_res_prv;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_st  = r_out_st;
        n_out_val = r_out_val;
        n_out_prv = r_out_prv;
        div_req.start    = 1'b0;
        div_req.dividend = DW'(r_b);
        div_req.divisor  = r_a;

        case (r_state)
            trsa_pkg::S_IDLE: begin
                if (accept) begin
                    n_res_val = '0;
                    n_res_prv = '0;
                    case (trsa_pkg::t_cmd'(s_axis_tuser))
                        trsa_pkg::CMD_LOAD: begin
                            n_res_st = trsa_pkg::ST_LOADED;
                            n_state  = trsa_pkg::S_FIN;
                        end
                        trsa_pkg::CMD_DERIVE: begin
                            if (r_tot < trsa_pkg::MIN_TOTIENT) begin
                                n_pub    = '0;
                                n_res_st = trsa_pkg::ST_NO_EXP;
                                n_state  = trsa_pkg::S_FIN;
                            end else begin
                                n_e     = MW'(2);
                                n_a     = MW'(2);
                                n_b     = r_tot;
                                n_state = trsa_pkg::S_GCD;
                            end
                        end
                        trsa_pkg::CMD_ENCRYPT: begin
                            n_key = trsa_pkg::fold_case(in_char);
                            if (32'(r_alen) > 32'(trsa_pkg::ALPHABET_DEPTH)) begin
                                n_len = NW'(trsa_pkg::ALPHABET_DEPTH);
                            end else begin
                                n_len = NW'(r_alen);
                            end
                            n_j     = '0;
                            n_state = trsa_pkg::S_SRCH;
                        end
                        default: ;
                    endcase
                end
            end
            trsa_pkg::S_FIN: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_st    = r_res_st;
                    n_out_val   = r_res_val;
                    n_out_prv   = r_res_prv;
                    n_state     = trsa_pkg::S_IDLE;
                end
            end
            trsa_pkg::S_SRCH: begin
                if (r_j >= r_len) begin
                    n_res_st = trsa_pkg::ST_NOT_FND;
                    n_state  = trsa_pkg::S_FIN;
                end else begin
                    n_state = trsa_pkg::S_SRCH_CHK;
                end
            end
            trsa_pkg::S_SRCH_CHK: begin
                if (ram_rdata == r_key) begin
                    n_pos    = r_j[AW-1:0];
                    n_res_st = trsa_pkg::ST_CIPHER;
                    if (r_mod == '0) begin
                        n_res_val = '0;
                        n_state   = trsa_pkg::S_FIN;
                    end else begin
                        n_c     = MW'(1);
                        n_h     = '0;
                        n_state = trsa_pkg::S_EXP;
                    end
                end else begin
                    n_j     = r_j + NW'(1);
                    n_state = trsa_pkg::S_SRCH;
                end
            end
            trsa_pkg::S_EXP: begin
                if (r_h == r_pub) begin
                    n_res_val = r_c;
                    n_state   = trsa_pkg::S_FIN;
                end else begin
                    n_prod  = PW'(r_c) * PW'(r_pos);
                    n_state = trsa_pkg::S_EXP_DIV;
                end
            end
            trsa_pkg::S_EXP_DIV: begin
                div_req.start    = 1'b1;
                div_req.dividend = DW'(r_prod);
                div_req.divisor  = r_mod;
                n_state          = trsa_pkg::S_EXP_WAIT;
            end
            trsa_pkg::S_EXP_WAIT: begin
                if (div_rsp.done) begin
                    n_c     = div_rsp.rem;
                    n_h     = r_h + MW'(1);
                    n_state = trsa_pkg::S_EXP;
                end
            end
            trsa_pkg::S_GCD: begin
                if (r_a == '0) begin
                    if (r_b == MW'(1)) begin
                        n_k     = DW'(1);
                        n_jd    = MW'(1);
                        n_state = trsa_pkg::S_D_ADD;
                    end else begin
                        n_e = r_e + MW'(1);
                        n_a = r_e + MW'(1);
                        n_b = r_tot;
                    end
                end else begin
                    div_req.start = 1'b1;
                    n_state       = trsa_pkg::S_GCD_WAIT;
                end
            end
            trsa_pkg::S_GCD_WAIT: begin
                if (div_rsp.done) begin
                    n_b     = r_a;
                    n_a     = div_rsp.rem;
                    n_state = trsa_pkg::S_GCD;
                end
            end
            trsa_pkg::S_D_ADD: begin
                n_k     = r_k + DW'(r_tot);
                n_state = trsa_pkg::S_D_DIV;
            end
            trsa_pkg::S_D_DIV: begin
                div_req.start    = 1'b1;
                div_req.dividend = r_k;
                div_req.divisor  = r_e;
                n_state          = trsa_pkg::S_D_WAIT;
            end
            trsa_pkg::S_D_WAIT: begin
                if (div_rsp.done) begin
                    if (div_rsp.rem == '0 || r_jd == r_e) begin
                        n_pub     = r_e;
                        n_res_st  = trsa_pkg::ST_KEYS;
                        n_res_val = r_e;
                        n_res_prv = (div_rsp.rem == '0) ? div_rsp.quot[MW-1:0] : '0;
                        n_state   = trsa_pkg::S_FIN;
                    end else begin
                        n_jd    = r_jd + MW'(1);
                        n_state = trsa_pkg::S_D_ADD;
                    end
                end
            end
            default: n_state = trsa_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= trsa_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_pub       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_pub       <= n_pub;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_len     <= n_len;
        r_j       <= n_j;
        r_pos     <= n_pos;
        r_e       <= n_e;
        r_a       <= n_a;
        r_b       <= n_b;
        r_k       <= n_k;
        r_jd      <= n_jd;
        r_c       <= n_c;
        r_h       <= n_h;
        r_prod    <= n_prod;
        r_res_st  <= n_res_st;
        r_res_val <= n_res_val;
        r_res_prv <= n_res_prv;
        r_out_st  <= n_out_st;
        r_out_val <= n_out_val;
        r_out_prv <= n_out_prv;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_st;
    assign m_axis_tdata  = {{(trsa_pkg::OUT_DATA_W - 2 * MW){1'b0}}, r_out_prv, r_out_val};

endmodule

`default_nettype wire

// File: design/trsa_chk.sv
// ----------------------------------------------------------------------------
// trsa_chk
// Port-level checks of the toy RSA engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module trsa_chk (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                m_axis_tvalid,
    input wire logic                                m_axis_tready,
    input wire logic [trsa_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input wire logic [trsa_pkg::STATUS_W-1:0]       m_axis_tuser
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

    a_rst: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == trsa_pkg::ST_LOADED ||
                           m_axis_tuser == trsa_pkg::ST_NOT_FND ||
                           m_axis_tuser == trsa_pkg::ST_NO_EXP)) |-> (m_axis_tdata == '0))
        else $error("nonzero data on status without payload");

    a_cipher: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == trsa_pkg::ST_CIPHER) |->
            (m_axis_tdata[trsa_pkg::OUT_DATA_W-1:trsa_pkg::MOD_WIDTH] == '0))
        else $error("private exponent shown with ciphertext");

endmodule

bind textbook_rsa_alphabet_encrypt_core trsa_chk u_trsa_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// File: tb/textbook_rsa_alphabet_encrypt_core_tb.sv
// ----------------------------------------------------------------------------
// textbook_rsa_alphabet_encrypt_core_tb
// Self-checking bench for the toy RSA core: loads the alphabet, derives keys
// and encrypts characters over several modulus/totient/length settings, with
// random gaps and stalls on both streams, and checks every result item.
// ----------------------------------------------------------------------------
`default_nettype none

module textbook_rsa_alphabet_encrypt_core_tb;

    localparam int  NUM_PHASES  = 8;
    localparam int  RAND_ITEMS  = 200;
    localparam int  CW          = trsa_pkg::CHAR_W;
    localparam int  SW          = trsa_pkg::SLOT_W;
    localparam int  MW          = trsa_pkg::MOD_WIDTH;
    localparam int  DEPTH       = trsa_pkg::ALPHABET_DEPTH;
    localparam longint CYCLE_LIMIT = 40000000;
    localparam longint unsigned WMASK = (64'd1 << MW) - 64'd1;

    typedef struct {
        trsa_pkg::t_cmd      cmd;
        logic [SW-1:0]       slot;
        logic [CW-1:0]       ch;
    } t_cmd_item;

    typedef struct {
        trsa_pkg::t_status    status;
        logic [MW-1:0]        value;
        logic [MW-1:0]        pexp;
    } t_rsa_result;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_cfg_we = 1'b0;
    logic [trsa_pkg::CFG_IDX_W-1:0]      i_cfg_idx = '0;
    logic [MW-1:0]                       i_cfg_data = '0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    logic [trsa_pkg::IN_DATA_W-1:0]      s_axis_tdata = '0;   // slot, character
    logic [trsa_pkg::CMD_W-1:0]          s_axis_tuser = '0;   // cmd
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    logic [trsa_pkg::OUT_DATA_W-1:0]     m_axis_tdata;        // value, private_exp
    logic [trsa_pkg::STATUS_W-1:0]       m_axis_tuser;        // status

    textbook_rsa_alphabet_encrypt_core dut (.*);

    always #2 i_clk = ~i_clk;

    // shadow state
    longint unsigned sh_mod = 3233, sh_tot = 3120, sh_len = 0, sh_pub = 0;
    logic [CW-1:0] sh_store [DEPTH];

    t_cmd_item   pending_cmds[$];
    t_rsa_result expected_results[$];
    t_cmd_item   cur;
    int          gap = 0, rgap = 0, sent_count = 0;
    bit          in_took = 0, running = 0, long_hold = 0, failed = 0;
    longint      cycles = 0;

    longint unsigned mods [NUM_PHASES] = '{3233, 2, 2147483647, 1000, 77, 77,
                                           2147483647, 0};
    longint unsigned tots [NUM_PHASES] = '{3120, 3120, 2147483646, 0, 1, 2,
                                           2147483647, 0};
    longint unsigned lens [NUM_PHASES] = '{26, 64, 127, 64, 10, 40, 64, 0};

    // characters for the first phase: folded ASCII, Cyrillic and the 0x04C0 pair
    logic [CW-1:0] ch_list [6] = '{16'h0041, 16'h0061, 16'h0410, 16'h0401,
                                   16'h04C0, 16'hFFFF};

    function automatic longint unsigned gcd_of(longint unsigned a, longint unsigned b);
        longint unsigned r;
        while (a > 0) begin
            r = b % a;
            b = a;
            a = r;
        end
        return b;
    endfunction

    function automatic logic [CW-1:0] to_lower(logic [CW-1:0] c);
        if (c inside {[16'h0041:16'h005A], [16'h0410:16'h042F]}) return c + 16'h20;
        if (c inside {[16'h0400:16'h040F]}) return c + 16'h50;
        if (c == 16'h04C0) return 16'h04CF;
        if (c inside {[16'h04C1:16'h04CE]}) return c + c[0];
        if (c inside {[16'h0460:16'h0481], [16'h048A:16'h04BF], [16'h04D0:16'h052F]})
            return c + !c[0];
        return c;
    endfunction

    function automatic logic [CW-1:0] to_upper(logic [CW-1:0] c);
        if (c inside {[16'h0061:16'h007A], [16'h0430:16'h044F]}) return c - 16'h20;
        if (c inside {[16'h0450:16'h045F]}) return c - 16'h50;
        if (c == 16'h04CF) return 16'h04C0;
        if (c[0] && c inside {[16'h04C1:16'h04CE], [16'h0460:16'h0481],
                              [16'h048A:16'h04BF], [16'h04D0:16'h052F]})
            return c - 16'h0001;
        return c;
    endfunction

    // updates shadow state and queues the expected result of every command but CMD_NONE
    function automatic void predict_result(t_cmd_item it);
        t_rsa_result r;
        longint unsigned e, k, d, c, n;
        logic [CW-1:0] key;
        int pos;
        r.status = trsa_pkg::ST_LOADED;
        r.value = '0;
        r.pexp = '0;
        case (it.cmd)
            trsa_pkg::CMD_LOAD: sh_store[it.slot] = it.ch;
            trsa_pkg::CMD_DERIVE: begin
                e = 2;
                while (e < sh_tot && gcd_of(e, sh_tot) != 1) e++;
                if (e >= sh_tot) begin
                    sh_pub = 0;
                    r.status = trsa_pkg::ST_NO_EXP;
                end else begin
                    k = 1;
                    d = 0;
                    for (longint unsigned j = 1; j <= e; j++) begin
                        k += sh_tot;
                        if (k % e == 0) begin
                            d = k / e;
                            break;
                        end
                    end
                    sh_pub = e & WMASK;
                    r.status = trsa_pkg::ST_KEYS;
                    r.value = MW'(e & WMASK);
                    r.pexp = MW'(d & WMASK);
                end
            end
            trsa_pkg::CMD_ENCRYPT: begin
                key = to_lower(it.ch);
                n = (sh_len > DEPTH) ? DEPTH : sh_len;
                pos = -1;
                for (int j = 0; j < n; j++) begin
                    if (sh_store[j] == key) begin
                        pos = j;
                        break;
                    end
                end
                if (pos < 0) begin
                    r.status = trsa_pkg::ST_NOT_FND;
                end else begin
                    c = 1;
                    if (sh_mod == 0) c = 0;
                    else for (longint unsigned h = 0; h < sh_pub; h++)
                        c = (c * longint'(pos)) % sh_mod;
                    r.status = trsa_pkg::ST_CIPHER;
                    r.value = MW'(c & WMASK);
                end
            end
            default: return;
        endcase
        expected_results = {expected_results, r};
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(99);
        if (p < 65) return 0;
        if (p < 95) return $urandom_range(3, 1);
        return $urandom_range(60, 20);
    endfunction

    // stored value at queue-build time; loads still queued may change it
    function automatic logic [CW-1:0] sh_store_peek(int s);
        return sh_store[s];
    endfunction

    function automatic logic [CW-1:0] rand_char();
        int p;
        p = $urandom_range(9);
        if (p < 4) return 16'h0061 + CW'($urandom_range(25));
        if (p < 7) return 16'h0430 + CW'($urandom_range(47));
        if (p < 8) return 16'h0460 + CW'($urandom_range(16'h0CF));
        return CW'($urandom_range(16'hFFFF));
    endfunction

    // sender and result-side ready
    always @(negedge i_clk) begin
        if (running) begin
            if (!s_axis_tvalid || in_took) begin
                if (gap > 0) begin
                    gap <= gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    cur = pending_cmds.pop_front();
                    s_axis_tdata <= {2'b00, cur.ch, cur.slot};
                    s_axis_tuser <= cur.cmd;
                    s_axis_tvalid <= 1'b1;
                    gap <= pick_gap();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            if (long_hold) begin
                m_axis_tready <= 1'b0;
            end else if (rgap > 0) begin
                rgap <= rgap - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(3) == 0) rgap <= pick_gap();
            end
        end
    end

    // acceptance and checking
    always @(posedge i_clk) begin
        t_rsa_result ex;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
        in_took <= s_axis_tvalid && s_axis_tready;
        if (s_axis_tvalid && s_axis_tready) begin
            predict_result(cur);
            sent_count <= sent_count + 1;
        end
        if (m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result status=%0d value=%0d d=%0d", $time,
                         m_axis_tuser, m_axis_tdata[30:0], m_axis_tdata[61:31]);
                failed = 1;
            end else begin
                ex = expected_results.pop_front();
                if (m_axis_tuser !== ex.status) begin
                    $display("%0t: status exp %0d got %0d", $time, ex.status, m_axis_tuser);
                    failed = 1;
                end
                if (m_axis_tdata[30:0] !== ex.value) begin
                    $display("%0t: value exp %0d got %0d", $time, ex.value,
                             m_axis_tdata[30:0]);
                    failed = 1;
                end
                if (m_axis_tdata[61:31] !== ex.pexp) begin
                    $display("%0t: private_exp exp %0d got %0d", $time, ex.pexp,
                             m_axis_tdata[61:31]);
                    failed = 1;
                end
            end
        end
    end

    task automatic cfg_write(logic [trsa_pkg::CFG_IDX_W-1:0] idx, longint unsigned val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val[MW-1:0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            trsa_pkg::CFG_MODULUS:  sh_mod = val & WMASK;
            trsa_pkg::CFG_TOTIENT:  sh_tot = val & WMASK;
            trsa_pkg::CFG_ALPH_LEN: sh_len = val & 64'h7F;
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (pending_cmds.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
            @(negedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic add_cmd(trsa_pkg::t_cmd c, logic [SW-1:0] s, logic [CW-1:0] ch);
        t_cmd_item it;
        it.cmd = c;
        it.slot = s;
        it.ch = ch;
        pending_cmds = {pending_cmds, it};
    endtask

    initial begin
        logic [CW-1:0] ch;
        int p, s;
        mods[7] = $urandom_range(32'h7FFF_FFFF, 2);
        tots[7] = $urandom_range(100000);
        lens[7] = $urandom_range(127);
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        running = 1;
        // all slots written first so no search reads an unwritten entry
        for (int i = 0; i < DEPTH; i++)
            add_cmd(trsa_pkg::CMD_LOAD, SW'(i),
                    (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF : rand_char());
        add_cmd(trsa_pkg::CMD_ENCRYPT, '0, 16'h0041);     // zero exponent, empty search
        add_cmd(trsa_pkg::CMD_NONE, 6'h3F, 16'hFFFF);
        add_cmd(trsa_pkg::CMD_LOAD, 6'd2, 16'h0061);
        add_cmd(trsa_pkg::CMD_LOAD, 6'd3, 16'h0430);
        add_cmd(trsa_pkg::CMD_LOAD, 6'd4, 16'h04CF);
        add_cmd(trsa_pkg::CMD_LOAD, 6'd5, 16'h0451);
        wait_idle();
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            cfg_write(trsa_pkg::CFG_MODULUS, mods[ph]);
            cfg_write(trsa_pkg::CFG_TOTIENT, tots[ph]);
            cfg_write(trsa_pkg::CFG_ALPH_LEN, lens[ph]);
            if (ph == 0) begin
                add_cmd(trsa_pkg::CMD_ENCRYPT, '0, 16'h0041);
                add_cmd(trsa_pkg::CMD_DERIVE, '0, '0);
                foreach (ch_list[i]) add_cmd(trsa_pkg::CMD_ENCRYPT, '0, ch_list[i]);
            end else begin
                add_cmd(trsa_pkg::CMD_DERIVE, '0, '0);
            end
            if (ph == 2) begin
                fork
                    begin
                        wait (sent_count > 250);
                        long_hold = 1;
                        repeat (2000) @(posedge i_clk);
                        long_hold = 0;
                    end
                join_none
            end
            for (int i = 0; i < RAND_ITEMS; i++) begin
                p = $urandom_range(99);
                if (p < 12) begin
                    add_cmd(trsa_pkg::CMD_LOAD, SW'($urandom_range(63)), rand_char());
                end else if (p < 17) begin
                    add_cmd(trsa_pkg::CMD_DERIVE, SW'($urandom_range(63)),
                            CW'($urandom_range(16'hFFFF)));
                end else if (p < 20) begin
                    add_cmd(trsa_pkg::CMD_NONE, SW'($urandom_range(63)),
                            CW'($urandom_range(16'hFFFF)));
                end else begin
                    s = $urandom_range(63);
                    ch = (p < 75) ? sh_store_peek(s) : rand_char();
                    if ($urandom_range(1)) ch = to_upper(ch);
                    add_cmd(trsa_pkg::CMD_ENCRYPT, SW'($urandom_range(63)), ch);
                end
            end
            wait_idle();
        end
        if (!failed) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
